// ----- rtl/ipv4fhg_pkg.sv -----
package ipv4fhg_pkg;

    // field widths
    localparam int unsigned HW_W     = 4;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned STATUS_W = 3;

    // packed bus widths, rounded up to whole bytes
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 88;

    // fragment limit and the size of the per-packet descriptor burst
    localparam int unsigned MAX_FRAGS  = 16;
    localparam int unsigned RESULT_CAP = 16;
    localparam int unsigned FRAG_LIMIT = (MAX_FRAGS < RESULT_CAP) ? MAX_FRAGS : RESULT_CAP;
    localparam int unsigned LIMIT_W    = $clog2(FRAG_LIMIT + 1);

    localparam logic [LEN_W-1:0] MTU_RESET = 16'd1500;

    typedef enum logic [STATUS_W-1:0] {
        ST_FRAG     = 3'd0,
        ST_PASS     = 3'd1,
        ST_ALREADY  = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_BAD_MTU  = 3'd4
    } t_status;

endpackage

// ----- rtl/ipv4_fragment_header_generator.sv -----
// IPv4 fragment descriptor generator. Each input word carries the IHL, total length,
// flags/offset and checksum fields of one IPv4 header; for it the block emits one
// output word per fragment (tuser status fragment, tlast on the final one) holding
// payload start and length, new total length, new flags/offset with MF on all but the
// last, and the header checksum patched incrementally. Packets that are already
// fragments, that fit the link, that would need more than the fragment limit, or that
// meet an mtu below the header plus 8 bytes give a single word with the matching status.
// The fragment sequencer emits one word per cycle unless the output stalls, and stays
// on a packet until its final word: a single word for a packet that is not cut, up to
// the fragment limit (16) otherwise. The front pipeline accepts a new header every
// cycle until the sequencer backs up. The mtu register resets to 1500 and is written on
// the config channel; the user must write it only while the block is idle, not enforced.
module ipv4_fragment_header_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel: link mtu in bytes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // header word in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] header_words, [19:4] packet_length, [35:20] flags_offset_in,
    // [51:36] checksum_in, [55:52] zero
    input  logic [ipv4fhg_pkg::S_TDATA_W-1:0] i_s_tdata,
    // descriptor word out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] frag_index, [19:4] payload_start, [35:20] payload_bytes,
    // [51:36] frag_total_length, [67:52] flags_offset_out, [83:68] checksum_out,
    // [87:84] zero
    output logic [ipv4fhg_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [2:0] status
    output logic [ipv4fhg_pkg::STATUS_W-1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int unsigned LW   = ipv4fhg_pkg::LEN_W;
    localparam int unsigned IW   = ipv4fhg_pkg::IDX_W;
    localparam int unsigned CAPW = LW + ipv4fhg_pkg::LIMIT_W;

    // ------------------------------------------------------------------
    // config register
    // ------------------------------------------------------------------
    logic [LW-1:0] r_link_mtu;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mtu <= ipv4fhg_pkg::MTU_RESET;
        end else if (i_cfg_valid) begin
            r_link_mtu <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // unpack input word
    // ------------------------------------------------------------------
    logic [3:0]    in_hw;
    logic [LW-1:0] in_plen;
    logic [LW-1:0] in_fo;
    logic [LW-1:0] in_ck;

    assign in_hw   = i_s_tdata[3:0];
    assign in_plen = i_s_tdata[19:4];
    assign in_fo   = i_s_tdata[35:20];
    assign in_ck   = i_s_tdata[51:36];

    // ------------------------------------------------------------------
    // stall chain: each stage loads when empty or when it is draining
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic r_x_busy, r_ve, r_vc;
    logic en1, en2, en3, s3_take;
    logic e_can, c_can, x_fire, x_last;

    assign c_can   = !r_vc || i_m_tready;
    assign e_can   = !r_ve || c_can;
    assign x_fire  = r_x_busy && e_can;
    assign s3_take = !r_x_busy || (x_fire && x_last);
    assign en3     = !r_v3 || s3_take;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;

    assign o_s_tready = en1;

    // ------------------------------------------------------------------
    // stage 1: header length, payload length, mtu margin, checksum base
    // ------------------------------------------------------------------
    logic [5:0]    s1_hl;
    logic [LW-1:0] s1_hl16;
    logic [17:0]   s1_base;

    assign s1_hl   = {in_hw, 2'b00};
    assign s1_hl16 = {{(LW-6){1'b0}}, s1_hl};
    // ~HC + ~m_len + ~m_fo, the part of the patch common to every fragment
    assign s1_base = {2'b00, ~in_ck} + {2'b00, ~in_plen} + {2'b00, ~in_fo};

    logic [5:0]    r1_hl;
    logic          r1_is_frag, r1_mtu_lt, r1_fits;
    logic [LW-1:0] r1_diff, r1_dlen, r1_plen, r1_fo, r1_ck;
    logic [17:0]   r1_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_hl      <= s1_hl;
            r1_is_frag <= (in_fo[13:0] != 14'd0);
            r1_mtu_lt  <= (r_link_mtu < s1_hl16);
            r1_diff    <= r_link_mtu - s1_hl16;
            r1_dlen    <= (in_plen >= s1_hl16) ? (in_plen - s1_hl16) : '0;
            r1_fits    <= (in_plen <= r_link_mtu);
            r1_plen    <= in_plen;
            r1_fo      <= in_fo;
            r1_ck      <= in_ck;
            r1_base    <= s1_base;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: fragment size, classification, burst capacity
    // ------------------------------------------------------------------
    logic [LW-1:0]             s2_fsize;
    logic                      s2_bad;
    logic                      s2_fits;
    logic [CAPW-1:0]           s2_cap;
    ipv4fhg_pkg::t_status      n2_status;

    assign s2_fsize = {r1_diff[LW-1:3], 3'b000};
    assign s2_bad   = r1_mtu_lt || (r1_diff[LW-1:3] == '0);
    assign s2_fits  = r1_fits || (r1_dlen <= s2_fsize);
    assign s2_cap   = CAPW'(s2_fsize) * CAPW'(ipv4fhg_pkg::FRAG_LIMIT);

    always_comb begin
        if (r1_is_frag) begin
            n2_status = ipv4fhg_pkg::ST_ALREADY;
        end else if (s2_bad) begin
            n2_status = ipv4fhg_pkg::ST_BAD_MTU;
        end else if (s2_fits) begin
            n2_status = ipv4fhg_pkg::ST_PASS;
        end else begin
            n2_status = ipv4fhg_pkg::ST_FRAG;
        end
    end

    ipv4fhg_pkg::t_status r2_status;
    logic [5:0]      r2_hl;
    logic [LW-1:0]   r2_fsize, r2_dlen, r2_plen, r2_fo, r2_ck;
    logic [CAPW-1:0] r2_cap;
    logic [17:0]     r2_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_status <= n2_status;
            r2_hl     <= r1_hl;
            r2_fsize  <= s2_fsize;
            r2_dlen   <= r1_dlen;
            r2_plen   <= r1_plen;
            r2_fo     <= r1_fo;
            r2_ck     <= r1_ck;
            r2_cap    <= s2_cap;
            r2_base   <= r1_base;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: reject packets beyond the fragment limit
    // ------------------------------------------------------------------
    ipv4fhg_pkg::t_status n3_status;

    always_comb begin
        n3_status = r2_status;
        if (r2_status == ipv4fhg_pkg::ST_FRAG && CAPW'(r2_dlen) > r2_cap) begin
            n3_status = ipv4fhg_pkg::ST_TOO_MANY;
        end
    end

    ipv4fhg_pkg::t_status r3_status;
    logic [5:0]    r3_hl;
    logic [LW-1:0] r3_fsize, r3_dlen, r3_plen, r3_fo, r3_ck;
    logic [17:0]   r3_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_status <= n3_status;
            r3_hl     <= r2_hl;
            r3_fsize  <= r2_fsize;
            r3_dlen   <= r2_dlen;
            r3_plen   <= r2_plen;
            r3_fo     <= r2_fo;
            r3_ck     <= r2_ck;
            r3_base   <= r2_base;
        end
    end

    // ------------------------------------------------------------------
    // fragment sequencer: one descriptor per cycle unless the output stalls, from running offset
    // and remaining payload
    // ------------------------------------------------------------------
    ipv4fhg_pkg::t_status r_x_status;
    logic [5:0]    r_x_hl;
    logic [LW-1:0] r_x_fsize, r_x_dlen, r_x_plen, r_x_fo, r_x_ck;
    logic [LW-1:0] r_x_off, r_x_rem;
    logic [IW-1:0] r_x_idx;
    logic [17:0]   r_x_base;

    logic          x_short;
    logic [LW-1:0] x_bytes;
    logic          x_load;

    assign x_load  = r_v3 && s3_take;
    assign x_short = (r_x_rem <= r_x_fsize);
    assign x_bytes = x_short ? r_x_rem : r_x_fsize;
    assign x_last  = (r_x_status != ipv4fhg_pkg::ST_FRAG) || x_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_busy <= 1'b0;
        end else if (x_load) begin
            r_x_busy <= 1'b1;
        end else if (x_fire && x_last) begin
            r_x_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_load) begin
            r_x_status <= r3_status;
            r_x_hl     <= r3_hl;
            r_x_fsize  <= r3_fsize;
            r_x_dlen   <= r3_dlen;
            r_x_plen   <= r3_plen;
            r_x_fo     <= r3_fo;
            r_x_ck     <= r3_ck;
            r_x_base   <= r3_base;
            r_x_off    <= '0;
            r_x_rem    <= r3_dlen;
            r_x_idx    <= '0;
        end else if (x_fire && !x_last) begin
            r_x_off <= r_x_off + r_x_fsize;
            r_x_rem <= r_x_rem - r_x_fsize;
            r_x_idx <= r_x_idx + 1'b1;
        end
    end

    // descriptor fields for the current sequencer slot
    logic [IW-1:0] n_e_idx;
    logic [LW-1:0] n_e_start, n_e_bytes, n_e_tlen, n_e_fo, n_e_ck;
    logic          n_e_upd;

    always_comb begin
        n_e_idx   = '0;
        n_e_start = '0;
        n_e_bytes = '0;
        n_e_tlen  = '0;
        n_e_fo    = '0;
        n_e_ck    = '0;
        n_e_upd   = 1'b0;
        case (r_x_status)
            ipv4fhg_pkg::ST_FRAG: begin
                n_e_idx   = r_x_idx;
                n_e_start = r_x_off;
                n_e_bytes = x_bytes;
                n_e_tlen  = {{(LW-6){1'b0}}, r_x_hl} + x_bytes;
                // MF on every fragment but the last, DF and reserved cleared
                n_e_fo    = {2'b00, !x_short, r_x_off[LW-1:3]};
                n_e_upd   = 1'b1;
            end
            ipv4fhg_pkg::ST_PASS: begin
                n_e_bytes = r_x_dlen;
                n_e_tlen  = r_x_plen;
                n_e_fo    = r_x_fo;
                n_e_ck    = r_x_ck;
            end
            default: begin
                // rejected packets carry only status and tlast
                n_e_upd = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // descriptor register
    // ------------------------------------------------------------------
    ipv4fhg_pkg::t_status r_e_status;
    logic [IW-1:0] r_e_idx;
    logic [LW-1:0] r_e_start, r_e_bytes, r_e_tlen, r_e_fo, r_e_ck;
    logic          r_e_upd, r_e_last;
    logic [17:0]   r_e_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (e_can) begin
            r_ve <= r_x_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_can) begin
            r_e_status <= r_x_status;
            r_e_idx    <= n_e_idx;
            r_e_start  <= n_e_start;
            r_e_bytes  <= n_e_bytes;
            r_e_tlen   <= n_e_tlen;
            r_e_fo     <= n_e_fo;
            r_e_ck     <= n_e_ck;
            r_e_upd    <= n_e_upd;
            r_e_last   <= x_last;
            r_e_base   <= r_x_base;
        end
    end

    // ------------------------------------------------------------------
    // checksum stage: add new length and flags/offset, end-around fold
    // ------------------------------------------------------------------
    logic [18:0]   c_sum;
    logic [16:0]   c_fold1;
    logic [LW-1:0] c_fold2;
    logic [LW-1:0] c_ck;

    assign c_sum   = {1'b0, r_e_base} + {3'b000, r_e_tlen} + {3'b000, r_e_fo};
    assign c_fold1 = {1'b0, c_sum[15:0]} + {14'd0, c_sum[18:16]};
    assign c_fold2 = c_fold1[15:0] + {15'd0, c_fold1[16]};
    assign c_ck    = r_e_upd ? ~c_fold2 : r_e_ck;

    ipv4fhg_pkg::t_status r_c_status;
    logic [IW-1:0] r_c_idx;
    logic [LW-1:0] r_c_start, r_c_bytes, r_c_tlen, r_c_fo, r_c_ck;
    logic          r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (c_can) begin
            r_vc <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_can) begin
            r_c_status <= r_e_status;
            r_c_idx    <= r_e_idx;
            r_c_start  <= r_e_start;
            r_c_bytes  <= r_e_bytes;
            r_c_tlen   <= r_e_tlen;
            r_c_fo     <= r_e_fo;
            r_c_ck     <= c_ck;
            r_c_last   <= r_e_last;
        end
    end

    assign o_m_tvalid = r_vc;
    assign o_m_tlast  = r_c_last;
    assign o_m_tuser  = r_c_status;
    assign o_m_tdata  = {4'd0, r_c_ck, r_c_fo, r_c_tlen, r_c_bytes, r_c_start, r_c_idx};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // only fragment words may leave a packet open
    a_open_is_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser == ipv4fhg_pkg::ST_FRAG)
        else $error("non-fragment word without tlast");

    // MF set exactly on non-final fragments
    a_mf_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ipv4fhg_pkg::ST_FRAG |-> o_m_tdata[65] == !o_m_tlast)
        else $error("MF bit disagrees with tlast");

    // sequencer stays on a packet until its final descriptor
    a_seq_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && !x_last |=> r_x_busy && r_x_idx == $past(r_x_idx) + 1'b1)
        else $error("sequencer left a packet early");

    // fragment count never runs past the limit
    a_idx_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_busy |-> {1'b0, r_x_idx} < ipv4fhg_pkg::LIMIT_W'(ipv4fhg_pkg::FRAG_LIMIT))
        else $error("fragment index beyond limit");

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned IDLE_PCT     = 27;
    localparam logic [15:0] MF_BIT       = 16'h2000;
    localparam logic [15:0] FRAG_MASK    = 16'h3FFF;

    // one ipv4 header as it enters the block
    typedef struct packed {
        logic [3:0]  words;
        logic [15:0] total_len;
        logic [15:0] flags_off;
        logic [15:0] csum;
    } t_header;

    // one fragment descriptor as it leaves the block
    typedef struct {
        ipv4fhg_pkg::t_status status;
        logic [3:0]  index;
        logic [15:0] start;
        logic [15:0] bytes;
        logic [15:0] total_len;
        logic [15:0] flags_off;
        logic [15:0] csum;
        logic        last;
    } t_descriptor;

    // fragment planner plus the queue of descriptors still owed by the block
    class t_fragment_checker;
        logic [15:0]  link_mtu;
        t_descriptor  pending_descriptors[$];
        int unsigned  failures;
        int unsigned  headers;
        int unsigned  mtu_writes;
        int unsigned  by_status[5];

        function new();
            link_mtu = ipv4fhg_pkg::MTU_RESET;
        endfunction

        function void set_mtu(input logic [15:0] mtu);
            link_mtu = mtu;
            mtu_writes++;
        endfunction

        function int unsigned pending();
            return pending_descriptors.size();
        endfunction

        // rfc 1624 patch of the two header words that change
        function logic [15:0] patch_checksum(input logic [15:0] old_ck, old_len, new_len,
                                             old_fo, new_fo);
            logic [15:0] n_ck, n_len, n_fo;
            int unsigned acc;
            n_ck  = ~old_ck;
            n_len = ~old_len;
            n_fo  = ~old_fo;
            acc = n_ck + n_len + new_len + n_fo + new_fo;
            while (acc > 32'hFFFF)
                acc = (acc & 32'hFFFF) + (acc >> 16);
            return ~acc[15:0];
        endfunction

        function void push_single(input ipv4fhg_pkg::t_status st,
                                  input logic [15:0] bytes, tlen, fo, ck);
            t_descriptor d;
            d.status    = st;
            d.index     = '0;
            d.start     = '0;
            d.bytes     = bytes;
            d.total_len = tlen;
            d.flags_off = fo;
            d.csum      = ck;
            d.last      = 1'b1;
            pending_descriptors.push_back(d);
        endfunction

        // work out every descriptor that one accepted header causes
        function void note_header(input t_header h);
            int unsigned hl, plen, fsize, dlen, nfr, off, rem;
            t_descriptor d;
            headers++;
            hl   = h.words * 4;
            plen = h.total_len;
            if ((h.flags_off & FRAG_MASK) != 0) begin
                push_single(ipv4fhg_pkg::ST_ALREADY, '0, '0, '0, '0);
                return;
            end
            if (link_mtu < hl) begin
                push_single(ipv4fhg_pkg::ST_BAD_MTU, '0, '0, '0, '0);
                return;
            end
            fsize = (link_mtu - hl) / 8 * 8;
            if (fsize < 8) begin
                push_single(ipv4fhg_pkg::ST_BAD_MTU, '0, '0, '0, '0);
                return;
            end
            dlen = (plen >= hl) ? plen - hl : 0;
            if (plen <= link_mtu || dlen <= fsize) begin
                push_single(ipv4fhg_pkg::ST_PASS, 16'(dlen), h.total_len, h.flags_off,
                            h.csum);
                return;
            end
            nfr = (dlen + fsize - 1) / fsize;
            if (nfr > ipv4fhg_pkg::FRAG_LIMIT) begin
                push_single(ipv4fhg_pkg::ST_TOO_MANY, '0, '0, '0, '0);
                return;
            end
            for (int unsigned i = 0; i < nfr; i++) begin
                off         = i * fsize;
                rem         = dlen - off;
                d.status    = ipv4fhg_pkg::ST_FRAG;
                d.index     = 4'(i);
                d.start     = 16'(off);
                d.bytes     = 16'((rem < fsize) ? rem : fsize);
                d.total_len = 16'(hl) + d.bytes;
                d.last      = (i + 1 == nfr);
                // df and reserved bits dropped, mf on all but the last
                d.flags_off = 16'(off >> 3) | (d.last ? 16'h0 : MF_BIT);
                d.csum      = patch_checksum(h.csum, h.total_len, d.total_len,
                                             h.flags_off, d.flags_off);
                pending_descriptors.push_back(d);
            end
        endfunction

        function void compare_field(input string name, input int unsigned want, got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_descriptor(input t_descriptor got);
            t_descriptor want;
            if (pending_descriptors.size() == 0) begin
                $error("descriptor word with nothing expected: status %0d index %0d",
                       got.status, got.index);
                failures++;
                return;
            end
            want = pending_descriptors.pop_front();
            if (want.status <= ipv4fhg_pkg::ST_BAD_MTU)
                by_status[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("frag_index", want.index, got.index);
            compare_field("payload_start", want.start, got.start);
            compare_field("payload_bytes", want.bytes, got.bytes);
            compare_field("frag_total_length", want.total_len, got.total_len);
            compare_field("flags_offset_out", want.flags_off, got.flags_off);
            compare_field("checksum_out", want.csum, got.csum);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [15:0]                            i_cfg_data;
    logic                                   i_s_tvalid;
    logic                                   o_s_tready;
    logic [ipv4fhg_pkg::S_TDATA_W-1:0]      i_s_tdata;
    logic                                   o_m_tvalid;
    logic                                   i_m_tready;
    logic [ipv4fhg_pkg::M_TDATA_W-1:0]      o_m_tdata;
    logic [ipv4fhg_pkg::STATUS_W-1:0]       o_m_tuser;
    logic                                   o_m_tlast;

    t_fragment_checker board;
    logic              calm;          // no idling on either side while set
    int unsigned       cycles;

    ipv4_fragment_header_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: stalls at random outside the calm stretch
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // descriptor word monitor
    always @(posedge i_clk) begin
        t_descriptor got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status    = ipv4fhg_pkg::t_status'(o_m_tuser);
            got.index     = o_m_tdata[3:0];
            got.start     = o_m_tdata[19:4];
            got.bytes     = o_m_tdata[35:20];
            got.total_len = o_m_tdata[51:36];
            got.flags_off = o_m_tdata[67:52];
            got.csum      = o_m_tdata[83:68];
            got.last      = o_m_tlast;
            board.check_descriptor(got);
        end
    end

    function automatic t_header make_header(input logic [3:0] words,
                                            input logic [15:0] len, fo, ck);
        t_header h;
        h.words     = words;
        h.total_len = len;
        h.flags_off = fo;
        h.csum      = ck;
        return h;
    endfunction

    // mostly packets that really get cut, with random content; the rest is noise
    function automatic t_header random_header(input int unsigned mtu);
        t_header     h;
        int unsigned hl, fsize, dlen, roll;
        roll    = $urandom_range(99);
        h.words = (roll < 85) ? 4'($urandom_range(15, 5)) : 4'($urandom_range(4, 0));
        hl      = h.words * 4;
        fsize   = (mtu >= hl) ? (mtu - hl) / 8 * 8 : 0;
        roll    = $urandom_range(99);
        if (roll < 65 && fsize >= 8) begin
            dlen = ($urandom_range(17, 1) - 1) * fsize + $urandom_range(fsize, 1);
            h.total_len = (hl + dlen > 65535) ? 16'($urandom) : 16'(hl + dlen);
        end else if (roll < 85) begin
            h.total_len = 16'($urandom_range(2 * mtu + 64, 0));
        end else begin
            h.total_len = 16'($urandom);
        end
        roll        = $urandom_range(99);
        h.flags_off = (roll < 78) ? {2'($urandom), 14'h0} : 16'($urandom);
        h.csum      = 16'($urandom);
        return h;
    endfunction

    // header word: [3:0] ihl, [19:4] total length, [35:20] flags/offset, [51:36] checksum
    task automatic send_header(input t_header h);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'h0, h.csum, h.flags_off, h.total_len, h.words};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_header(h);
    endtask

    // wait for every owed descriptor, then let the pipeline run dry
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mtu(input logic [15:0] mtu);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mtu;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_mtu(mtu);
    endtask

    task automatic run_phase(input logic [15:0] mtu, input int unsigned count,
                             input logic quiet);
        settle();
        calm <= quiet;
        write_mtu(mtu);
        repeat (count) send_header(random_header(mtu));
    endtask

    initial begin
        board       = new();
        calm        <= 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset mtu of 1500
        send_header(make_header(4'd5, 16'd1500, 16'h0000, 16'h1234));   // fits exactly
        send_header(make_header(4'd5, 16'd1501, 16'h4000, 16'hB1E6));   // df set, two pieces
        send_header(make_header(4'd5, 16'd4000, 16'h0000, 16'hFFFF));
        send_header(make_header(4'd15, 16'hFFFF, 16'h0000, 16'h0000));  // far too many
        send_header(make_header(4'd5, 16'd0, 16'h0000, 16'h0000));      // shorter than header
        send_header(make_header(4'd0, 16'd3000, 16'h0000, 16'h8000));   // zero-length header
        send_header(make_header(4'd4, 16'd19, 16'h0000, 16'h00FF));
        send_header(make_header(4'd5, 16'd3000, MF_BIT, 16'h4321));     // already a fragment
        send_header(make_header(4'd5, 16'd3000, 16'h0001, 16'h4321));
        send_header(make_header(4'd5, 16'd3000, 16'h1FFF, 16'h4321));
        send_header(make_header(4'd5, 16'd9000, 16'hC000, 16'hA5A5));   // df and reserved
        send_header(make_header(4'd5, 16'd23700, 16'h0000, 16'h0F0F)); // exactly the limit
        send_header(make_header(4'd5, 16'd23701, 16'h0000, 16'h0F0F)); // one over the limit
        send_header(make_header(4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_header(make_header(4'd15, 16'd1500, 16'h0000, 16'h7777));
        send_header(make_header(4'd7, 16'd1600, 16'h8000, 16'h5555));

        // smallest legal piece size
        settle();
        write_mtu(16'd28);
        send_header(make_header(4'd5, 16'd100, 16'h0000, 16'h1111));    // ten 8-byte pieces
        send_header(make_header(4'd5, 16'd148, 16'h0000, 16'h2222));    // sixteen pieces
        send_header(make_header(4'd6, 16'd28, 16'h0000, 16'h3333));     // piece size below 8
        send_header(make_header(4'd8, 16'd200, 16'h0000, 16'h4444));    // mtu below header

        run_phase(16'd0, 40, 1'b0);
        run_phase(16'hFFFF, 40, 1'b0);
        run_phase(16'd576, 40, 1'b1);
        run_phase(16'd68, 40, 1'b0);
        run_phase(16'd1280, 40, 1'b0);
        run_phase(16'd9000, 40, 1'b0);
        run_phase(16'($urandom), 40, 1'b0);
        run_phase(16'($urandom_range(200, 20)), 40, 1'b0);
        run_phase(16'd1500, 40, 1'b0);
        settle();

        $display("checked %0d headers across %0d mtu settings, calm stretch included",
                 board.headers, board.mtu_writes + 1);
        $display("descriptors: cut %0d, passed %0d, fragments %0d, too many %0d, bad mtu %0d",
                 board.by_status[ipv4fhg_pkg::ST_FRAG],
                 board.by_status[ipv4fhg_pkg::ST_PASS],
                 board.by_status[ipv4fhg_pkg::ST_ALREADY],
                 board.by_status[ipv4fhg_pkg::ST_TOO_MANY],
                 board.by_status[ipv4fhg_pkg::ST_BAD_MTU]);
        if (board.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ipv4fhg_pkg.sv
rtl/ipv4_fragment_header_generator.sv
test/tb.sv
